[rtl/core/irdq_pkg.sv]
`default_nettype none
package irdq_pkg;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ENTRY_W     = 2 * BYTE_W;
  localparam int unsigned CFG_IDX_W   = 2;

  // request codes
  typedef enum logic [1:0] {
    REQ_POST    = 2'd0,
    REQ_TAKE    = 2'd1,
    REQ_REQUEUE = 2'd2
  } req_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_CODE   = 2'd0,
    CFG_URGENT_LIMIT = 2'd1,
    CFG_EMPTY_CODE   = 2'd2
  } cfg_idx_e;

  // per-cycle operation broadcast to the cell row
  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_FLUSH   = 3'd1,
    OP_FRONT   = 3'd2,
    OP_BACK    = 3'd3,
    OP_TAKE    = 3'd4,
    OP_REQUEUE = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [CNT_W-1:0]     count;
    logic [ENTRY_W-1:0]   entry;
    logic [ENTRY_W-1:0]   head;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] int_code;
    logic [BYTE_W-1:0] unit_num;
  } irdq_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] spec_word;
    logic               raise_irq;
    logic               dropped;
  } irdq_out_t;

endpackage
`default_nettype wire

[rtl/core/irdq_cell.sv]
`default_nettype none
module irdq_cell
  import irdq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [IDX_W-1:0]   idx_i,
  input  wire cell_ctl_t          ctl_i,
  input  wire logic [ENTRY_W-1:0] prev_i,
  input  wire logic [ENTRY_W-1:0] next_i,
  output logic      [ENTRY_W-1:0] entry_o
);

  logic [ENTRY_W-1:0] entry_q;
  logic [ENTRY_W-1:0] entry_d;
  logic [CNT_W-1:0]   pos;
  logic               is_head;

  assign pos     = CNT_W'(idx_i);
  assign is_head = (pos == '0);

  // choose own value, a neighbor's value, a new entry or the head entry
  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      OP_FLUSH: begin
        if (is_head) entry_d = ctl_i.entry;
      end
      OP_FRONT: begin
        entry_d = is_head ? ctl_i.entry : prev_i;
      end
      OP_BACK: begin
        if (pos == ctl_i.count) entry_d = ctl_i.entry;
      end
      OP_TAKE: begin
        entry_d = next_i;
      end
      OP_REQUEUE: begin
        entry_d = (pos + CNT_W'(1) == ctl_i.count) ? ctl_i.head : next_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

[rtl/core/irdq_ctrl.sv]
`default_nettype none
module irdq_ctrl
  import irdq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire irdq_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output irdq_out_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  input  wire logic [ENTRY_W-1:0]   head_i,
  output cell_ctl_t                 ctl_o
);

  logic [BYTE_W-1:0] reset_code_q, urgent_limit_q, empty_code_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  irdq_out_t         out_data_q, res_d;
  logic              accept;
  logic              is_empty, is_full;
  cell_op_e          op;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CNT_W'(QUEUE_DEPTH));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_code_q   <= '0;
      urgent_limit_q <= '0;
      empty_code_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RESET_CODE:   reset_code_q   <= cfg_data_i;
        CFG_URGENT_LIMIT: urgent_limit_q <= cfg_data_i;
        CFG_EMPTY_CODE:   empty_code_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request decode: cell operation, new count and result
  always_comb begin
    op      = OP_HOLD;
    count_d = count_q;
    res_d   = '0;
    unique case (in_data_i.req_type)
      REQ_POST: begin
        if (in_data_i.int_code == reset_code_q) begin
          op              = OP_FLUSH;
          count_d         = CNT_W'(1);
          res_d.raise_irq = 1'b1;
        end else if (is_full) begin
          res_d.dropped = 1'b1;
        end else if (in_data_i.int_code <= urgent_limit_q) begin
          op              = OP_FRONT;
          count_d         = count_q + CNT_W'(1);
          res_d.raise_irq = 1'b1;
        end else begin
          op              = OP_BACK;
          count_d         = count_q + CNT_W'(1);
          res_d.raise_irq = is_empty;
        end
      end
      REQ_TAKE: begin
        if (is_empty) begin
          res_d.spec_word = {empty_code_q, BYTE_W'(0)};
        end else begin
          op              = OP_TAKE;
          count_d         = count_q - CNT_W'(1);
          res_d.spec_word = head_i;
          res_d.raise_irq = (count_q != CNT_W'(1));
        end
      end
      REQ_REQUEUE: begin
        if (!is_empty) begin
          op              = OP_REQUEUE;
          res_d.raise_irq = 1'b1;
        end
      end
      default: ;
    endcase
    if (!accept) op = OP_HOLD;
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign ctl_o.op    = op;
  assign ctl_o.count = count_q;
  assign ctl_o.entry = {in_data_i.int_code, in_data_i.unit_num};
  assign ctl_o.head  = head_i;

endmodule
`default_nettype wire

[rtl/core/interrupt_report_deque_unit.sv]
`default_nettype none
// Pending-interrupt deque. Entries live in a row of QUEUE_DEPTH cells, cell 0
// always holding the head; a front post shifts the row toward the tail, take
// and requeue shift it toward the head, and a back post writes the cell whose
// position equals the fill count. Every request is applied when accepted, so a
// new transaction is accepted each cycle while the registered result is being
// taken; that result is valid in the cycle after acceptance. Configuration writes
// are accepted every cycle; writes to an index beyond the three registers are
// ignored. No clearing pass follows reset: only cells below the fill count are
// ever read.
module interrupt_report_deque_unit
  import irdq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire irdq_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output irdq_out_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i
);

  cell_ctl_t          ctl;
  logic [ENTRY_W-1:0] entry [QUEUE_DEPTH];

  // request decode, count and result register
  irdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (entry[0]),
    .ctl_o       (ctl)
  );

  // row of entry cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = entry[i];
    end else begin : g_mid_prev
      assign prev = entry[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next = entry[i];
    end else begin : g_mid_next
      assign next = entry[i+1];
    end

    irdq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctl_i   (ctl),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (entry[i])
    );
  end

endmodule
`default_nettype wire
